>>> hdl/assert_macros.svh
// Assertion helpers; every user clocks on i_clk and resets on i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/gmt_pkg.sv
package gmt_pkg;

    localparam int DEF_MAX_COLUMNS = 1024;
    localparam int DEF_MAX_ROWS    = 1024;

    localparam int IDX_W   = 20;
    localparam int IN_W    = 320;
    localparam int OUT_W   = 184;
    localparam int CFG_W   = 32;
    localparam int CFG_AW  = 3;

    localparam logic signed [31:0] RST_SIZE  = 32'sd65536;
    localparam logic        [30:0] RST_SCALE = 31'd65536;
    localparam logic        [19:0] RST_MODE  = 20'd2048;

    typedef enum logic [CFG_AW-1:0] {
        CFG_SIZE_X   = 3'd0,
        CFG_SIZE_Y   = 3'd1,
        CFG_SIZE_Z   = 3'd2,
        CFG_ORIGIN_X = 3'd3,
        CFG_ORIGIN_Y = 3'd4,
        CFG_ORIGIN_Z = 3'd5,
        CFG_SCALE    = 3'd6,
        CFG_MODE     = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CMB_SUM = 2'd0,
        CMB_MIN = 2'd1,
        CMB_MAX = 2'd2,
        CMB_ALT = 2'd3
    } t_combine;

    typedef enum logic [1:0] {
        PLN_XY  = 2'd0,
        PLN_XZ  = 2'd1,
        PLN_YZ  = 2'd2,
        PLN_ALT = 2'd3
    } t_plane;

    typedef enum logic [1:0] {
        WND_FRONT = 2'd0,
        WND_BACK  = 2'd1,
        WND_BOTH  = 2'd2,
        WND_ALT   = 2'd3
    } t_wind;

    typedef enum logic [1:0] {
        CRN_BL = 2'd0,
        CRN_BR = 2'd1,
        CRN_TL = 2'd2,
        CRN_TR = 2'd3
    } t_corner;

    // Corner order per triangle pair, first corner in the low bits.
    localparam logic [11:0] SEQ_FRONT      = {CRN_TL, CRN_TR, CRN_BR, CRN_TL, CRN_BR, CRN_BL};
    localparam logic [11:0] SEQ_FRONT_DIAG = {CRN_TL, CRN_TR, CRN_BL, CRN_TR, CRN_BR, CRN_BL};
    localparam logic [11:0] SEQ_BACK       = {CRN_TR, CRN_TL, CRN_BR, CRN_BR, CRN_TL, CRN_BL};
    localparam logic [11:0] SEQ_BACK_DIAG  = {CRN_TR, CRN_BL, CRN_BR, CRN_TR, CRN_TL, CRN_BL};

    function automatic t_corner corner_at(input logic back, input logic diag,
                                          input logic [2:0] j);
        logic [11:0] seq;
        case ({back, diag})
            2'b00:   seq = SEQ_FRONT;
            2'b01:   seq = SEQ_FRONT_DIAG;
            2'b10:   seq = SEQ_BACK;
            default: seq = SEQ_BACK_DIAG;
        endcase
        return t_corner'(seq[{j, 1'b0} +: 2]);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
        if (v > 51'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -51'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [49:0] combine(input logic [1:0] code,
                                                   input logic signed [48:0] a,
                                                   input logic signed [48:0] b);
        case (code)
            CMB_MIN: return (a < b) ? 50'(a) : 50'(b);
            CMB_MAX: return (a > b) ? 50'(a) : 50'(b);
            default: return 50'(a) + 50'(b);
        endcase
    endfunction

endpackage

>>> hdl/grid_mesh_tessellator.sv
// Grid mesh tessellator.
// Input stream (s_axis): one grid point per transaction, row-major order; tuser is
// first_point, which restarts the row, column and vertex counters. Output stream
// (m_axis): per point one vertex transaction (tuser 0) and, past the first row and
// column, 6 or 12 triangle-index transactions (tuser 1); tlast marks the final one.
// Configuration: i_cfg_we/i_cfg_addr/i_cfg_data write one register per cycle;
// the user writes only while no point is in flight; the block does not enforce it.
// Sequence: one 33x33 multiplier is reused nine times, each use through the load,
// multiply and accumulate states, plus the combine, origin add and diagonal select
// states: the vertex is presented first, followed by the indices one per cycle
// while the receiver is ready. The next point is taken once the last result is in
// the output register, so points do not overlap in the shared multiplier sequence.
// Reset (synchronous, i_rst_n low) restores the register defaults and clears the
// counters; the previous-row z buffer is not cleared and needs no pass.
// A stalled receiver holds the output register; the sequencer waits on it.
module grid_mesh_tessellator
    import gmt_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // row_ratio, row_y_ratio, row_y_add, row_z_ratio, row_z_add,
    // col_ratio, col_x_ratio, col_x_add, col_z_ratio, col_z_add
    input  logic [IN_W-1:0]   s_axis_tdata,
    // first_point
    input  logic              s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // vert_x, vert_y, vert_z, tex_u, tex_v, tri_index, zero pad
    output logic [OUT_W-1:0]  m_axis_tdata,
    // kind
    output logic              m_axis_tuser,
    output logic              m_axis_tlast,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    localparam int CW  = $clog2(MAX_COLUMNS);
    localparam int CLW = CW + 1;
    localparam int RW  = $clog2(MAX_ROWS);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_LOAD = 8'b0000_0010,
        ST_MULT = 8'b0000_0100,
        ST_ACC  = 8'b0000_1000,
        ST_COMB = 8'b0001_0000,
        ST_ORIG = 8'b0010_0000,
        ST_DIAG = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } t_state;

    t_state r_state;

    logic signed [31:0] r_size [3];
    logic signed [31:0] r_origin [3];
    logic        [30:0] r_scale;
    logic        [19:0] r_mode;

    logic signed [31:0] r_in [10];

    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic [IDX_W-1:0] r_vc;

    logic [3:0]         r_k;
    logic signed [48:0] r_term [6];
    logic signed [49:0] r_m [3];
    logic signed [31:0] r_s [3];
    logic signed [31:0] r_v [3];

    logic signed [31:0] r_mem [MAX_COLUMNS];
    logic signed [31:0] r_br_z;
    logic signed [31:0] r_bl_z;
    logic signed [31:0] r_left_z;

    logic [IDX_W-1:0] r_idx [4];
    logic             r_diag;
    logic [3:0]       r_cnt;
    logic [3:0]       r_slot;

    logic               r_ovalid;
    logic [OUT_W-1:0]   r_odata;
    logic               r_okind;
    logic               r_olast;

    logic               w_accept;
    logic [CLW-1:0]     w_cols;
    logic               w_mul_load;
    logic signed [32:0] w_opa;
    logic signed [32:0] w_opb;
    logic signed [31:0] w_add;
    logic signed [47:0] w_q;
    logic signed [49:0] w_ax;
    logic signed [49:0] w_ay;
    logic signed [49:0] w_az;
    logic signed [32:0] w_d1;
    logic signed [32:0] w_d2;
    logic        [32:0] w_a1;
    logic        [32:0] w_a2;
    logic [CLW-1:0]     w_col_inc;
    logic [IDX_W-1:0]   w_cols_ext;
    logic               w_load_out;
    logic               w_back;
    logic [2:0]         w_j;
    t_corner            w_crn;
    logic [3:0]         w_k_next;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_cols_ext = IDX_W'(w_cols);
    assign w_col_inc  = CLW'(r_col) + CLW'(1);
    assign w_k_next   = r_k + 4'd1;

    always_comb begin
        if (r_mode[19:10] == 10'd0)
            w_cols = CLW'(1);
        else if (32'(r_mode[19:10]) > 32'(MAX_COLUMNS))
            w_cols = CLW'(MAX_COLUMNS);
        else
            w_cols = CLW'(r_mode[19:10]);
    end

    // operand select for the shared multiplier
    always_comb begin
        w_opa = 33'(r_size[0]);
        w_opb = 33'(r_in[0]);
        w_add = '0;
        case (r_k)
            4'd0: begin w_opa = 33'(r_size[0]); w_opb = 33'(r_in[0]); end
            4'd1: begin w_opa = 33'(r_size[0]); w_opb = 33'(r_in[6]); w_add = r_in[7]; end
            4'd2: begin w_opa = 33'(r_size[1]); w_opb = 33'(r_in[1]); w_add = r_in[2]; end
            4'd3: begin w_opa = 33'(r_size[1]); w_opb = 33'(r_in[5]); end
            4'd4: begin w_opa = 33'(r_size[2]); w_opb = 33'(r_in[3]); w_add = r_in[4]; end
            4'd5: begin w_opa = 33'(r_size[2]); w_opb = 33'(r_in[8]); w_add = r_in[9]; end
            4'd6: begin w_opa = 33'(r_s[0]); w_opb = $signed({2'b00, r_scale}); end
            4'd7: begin w_opa = 33'(r_s[1]); w_opb = $signed({2'b00, r_scale}); end
            4'd8: begin w_opa = 33'(r_s[2]); w_opb = $signed({2'b00, r_scale}); end
            default: begin w_opa = '0; w_opb = '0; end
        endcase
    end

    assign w_mul_load = (r_state == ST_LOAD);

    gmt_mul u_mul (
        .i_clk  (i_clk),
        .i_load (w_mul_load),
        .i_a    (w_opa),
        .i_b    (w_opb),
        .o_q    (w_q)
    );

    assign w_ax = combine(r_mode[3:2], r_term[0], r_term[1]);
    assign w_ay = combine(r_mode[5:4], r_term[2], r_term[3]);
    assign w_az = combine(r_mode[7:6], r_term[4], r_term[5]);

    assign w_d1 = 33'(r_bl_z) - 33'(r_v[2]);
    assign w_d2 = 33'(r_br_z) - 33'(r_left_z);
    assign w_a1 = w_d1[32] ? 33'(-w_d1) : 33'(w_d1);
    assign w_a2 = w_d2[32] ? 33'(-w_d2) : 33'(w_d2);

    assign w_load_out = (r_state == ST_OUT) && (!r_ovalid || m_axis_tready);
    assign w_j        = (r_slot > 4'd6) ? 3'(r_slot - 4'd7) : 3'(r_slot - 4'd1);
    assign w_back     = (t_wind'(r_mode[9:8]) == WND_BACK) ? 1'b1 : (r_slot > 4'd6);
    assign w_crn      = corner_at(w_back, r_diag, w_j);

    // line buffer of the previous row's z, registered read
    always_ff @(posedge i_clk) begin
        r_br_z <= r_mem[r_col];
        if (r_state == ST_DIAG)
            r_mem[r_col] <= r_v[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size   <= '{RST_SIZE, RST_SIZE, RST_SIZE};
            r_origin <= '{32'sd0, 32'sd0, 32'sd0};
            r_scale  <= RST_SCALE;
            r_mode   <= RST_MODE;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_SIZE_X:   r_size[0]   <= i_cfg_data;
                CFG_SIZE_Y:   r_size[1]   <= i_cfg_data;
                CFG_SIZE_Z:   r_size[2]   <= i_cfg_data;
                CFG_ORIGIN_X: r_origin[0] <= i_cfg_data;
                CFG_ORIGIN_Y: r_origin[1] <= i_cfg_data;
                CFG_ORIGIN_Z: r_origin[2] <= i_cfg_data;
                CFG_SCALE:    r_scale     <= i_cfg_data[30:0];
                CFG_MODE:     r_mode      <= i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    // payload registers of the datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int i = 0; i < 10; i++)
                r_in[i] <= s_axis_tdata[32*i +: 32];
        end
        if (r_state == ST_ACC) begin
            if (r_k < 4'd6)
                r_term[r_k[2:0]] <= $signed({w_q[47], w_q}) + 49'(w_add);
            else
                r_v[2'(r_k - 4'd6)] <= sat32(51'(w_q));
        end
        if (r_state == ST_COMB) begin
            case (t_plane'(r_mode[1:0]))
                PLN_XZ:  r_m <= '{w_ax, w_az, w_ay};
                PLN_YZ:  r_m <= '{w_az, w_ay, w_ax};
                default: r_m <= '{w_ax, w_ay, w_az};
            endcase
        end
        if (r_state == ST_ORIG) begin
            for (int i = 0; i < 3; i++)
                r_s[i] <= sat32(51'(r_m[i]) + 51'(r_origin[i]));
        end
        if (r_state == ST_DIAG) begin
            r_idx[CRN_TR] <= r_vc;
            r_idx[CRN_TL] <= r_vc - IDX_W'(1);
            r_idx[CRN_BR] <= r_vc - w_cols_ext;
            r_idx[CRN_BL] <= r_vc - w_cols_ext - IDX_W'(1);
            r_diag        <= (w_a1 > w_a2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_col    <= '0;
            r_row    <= '0;
            r_vc     <= '0;
            r_k      <= '0;
            r_bl_z   <= '0;
            r_left_z <= '0;
            r_cnt    <= '0;
            r_slot   <= '0;
            r_ovalid <= 1'b0;
            r_odata  <= '0;
            r_okind  <= 1'b0;
            r_olast  <= 1'b0;
        end else begin
            if (m_axis_tready && !w_load_out)
                r_ovalid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_k     <= '0;
                        r_state <= ST_LOAD;
                        if (s_axis_tuser) begin
                            r_col <= '0;
                            r_row <= '0;
                            r_vc  <= '0;
                        end else if (CLW'(r_col) >= w_cols) begin
                            r_col <= '0;
                            if (r_row != RW'(MAX_ROWS - 1))
                                r_row <= r_row + RW'(1);
                        end
                    end
                end
                ST_LOAD: r_state <= ST_MULT;
                ST_MULT: r_state <= ST_ACC;
                ST_ACC: begin
                    r_k <= w_k_next;
                    if (r_k == 4'd5)
                        r_state <= ST_COMB;
                    else if (r_k == 4'd8)
                        r_state <= ST_DIAG;
                    else
                        r_state <= ST_LOAD;
                end
                ST_COMB: r_state <= ST_ORIG;
                ST_ORIG: r_state <= ST_LOAD;
                ST_DIAG: begin
                    if (r_row != '0 && r_col != '0)
                        r_cnt <= (t_wind'(r_mode[9:8]) == WND_FRONT ||
                                  t_wind'(r_mode[9:8]) == WND_BACK) ? 4'd6 : 4'd12;
                    else
                        r_cnt <= 4'd0;
                    r_slot   <= '0;
                    r_bl_z   <= r_br_z;
                    r_left_z <= r_v[2];
                    r_vc     <= r_vc + IDX_W'(1);
                    if (w_col_inc >= w_cols) begin
                        r_col <= '0;
                        if (r_row != RW'(MAX_ROWS - 1))
                            r_row <= r_row + RW'(1);
                    end else begin
                        r_col <= w_col_inc[CW-1:0];
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (w_load_out) begin
                        r_ovalid <= 1'b1;
                        r_olast  <= (r_slot == r_cnt);
                        if (r_slot == 4'd0) begin
                            r_okind <= 1'b0;
                            r_odata <= OUT_W'({r_idx[CRN_TR], r_in[5], r_in[0],
                                               r_v[2], r_v[1], r_v[0]});
                        end else begin
                            r_okind <= 1'b1;
                            r_odata <= OUT_W'({r_idx[w_crn], 160'd0});
                        end
                        r_slot <= r_slot + 4'd1;
                        if (r_slot == r_cnt)
                            r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;

    `include "assert_macros.svh"

    `ASSERT_NEXT(a_accept_starts, w_accept, r_state == ST_LOAD, "accept did not start sequence")
    `ASSERT_IMPL(a_slot_bound, r_state == ST_OUT, r_slot <= r_cnt, "output slot past count")
    `ASSERT_IMPL(a_index_clean, m_axis_tvalid && m_axis_tuser, m_axis_tdata[159:0] == '0,
                 "index result carries vertex data")

endmodule

>>> hdl/gmt_mul.sv
module gmt_mul
    import gmt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_load,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [47:0] o_q
);

    logic signed [32:0] r_a;
    logic signed [32:0] r_b;
    logic signed [63:0] r_p;
    logic signed [65:0] w_full;
    logic signed [63:0] w_rnd;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        r_p <= w_full[63:0];
    end

    assign w_full = r_a * r_b;
    // round half up: add one half LSB, then floor shift
    assign w_rnd  = r_p + 64'sd32768;
    assign o_q    = w_rnd[63:16];

endmodule

>>> verif/grid_mesh_tessellator_tb.sv
`timescale 1ns / 1ps

module grid_mesh_tessellator_tb
    import gmt_pkg::*;
();

    localparam int LIMIT_CYCLES = 1500000;

    typedef struct packed {
        logic        kind;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        logic [31:0] tu;
        logic [31:0] tv;
        logic [19:0] idx;
        logic        lst;
    } t_mesh_out;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;
    logic              s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              m_axis_tuser;
    logic              m_axis_tlast;
    logic              i_cfg_we;
    logic [CFG_AW-1:0] i_cfg_addr;
    logic [CFG_W-1:0]  i_cfg_data;

    grid_mesh_tessellator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    // predictor state
    logic signed [31:0] m_size [3];
    logic signed [31:0] m_origin [3];
    logic [30:0]        m_scale;
    logic [19:0]        m_mode;
    logic signed [31:0] line_z [DEF_MAX_COLUMNS];
    logic signed [31:0] corner_bl_z, left_z;
    int unsigned        row_cnt, col_cnt;
    logic [19:0]        vert_cnt;

    t_mesh_out pending_q[$];
    int  errors;
    int  n_items, n_results, n_tris;
    longint cycle;
    bit   rx_hold_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > LIMIT_CYCLES) begin
            $display("TIMEOUT at %0t", $time);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [63:0] p;
        p = a * b + 64'sd32768;
        return p >>> 16;
    endfunction

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic signed [63:0] merge_axis(input logic [1:0] code,
                                                      input logic signed [63:0] a,
                                                      input logic signed [63:0] b);
        case (t_combine'(code))
            CMB_MIN: return (a < b) ? a : b;
            CMB_MAX: return (a > b) ? a : b;
            default: return a + b;
        endcase
    endfunction

    function automatic logic signed [63:0] sx(input logic [31:0] v);
        return 64'(signed'(v));
    endfunction

    task automatic predict_point(input logic fp, input logic [31:0] f [10]);
        logic signed [63:0] ax, ay, az, d1, d2;
        logic signed [63:0] m [3];
        logic signed [31:0] v [3];
        logic signed [31:0] br_z;
        int unsigned cols;
        logic [19:0] tr, tl, br, bl;
        logic [19:0] seq [$];
        logic diag;
        t_wind wnd;
        t_mesh_out o;
        cols = m_mode[19:10];
        if (cols == 0) cols = 1;
        wnd = t_wind'(m_mode[9:8]);
        if (fp) begin
            row_cnt = 0; col_cnt = 0; vert_cnt = '0;
        end else if (col_cnt >= cols) begin
            col_cnt = 0;
            if (row_cnt < DEF_MAX_ROWS - 1) row_cnt++;
        end
        ax = merge_axis(m_mode[3:2], fx_mul(m_size[0], sx(f[0])),
                        fx_mul(m_size[0], sx(f[6])) + sx(f[7]));
        ay = merge_axis(m_mode[5:4], fx_mul(m_size[1], sx(f[1])) + sx(f[2]),
                        fx_mul(m_size[1], sx(f[5])));
        az = merge_axis(m_mode[7:6], fx_mul(m_size[2], sx(f[3])) + sx(f[4]),
                        fx_mul(m_size[2], sx(f[8])) + sx(f[9]));
        case (t_plane'(m_mode[1:0]))
            PLN_XZ: begin m[0] = ax; m[1] = az; m[2] = ay; end
            PLN_YZ: begin m[0] = az; m[1] = ay; m[2] = ax; end
            default: begin m[0] = ax; m[1] = ay; m[2] = az; end
        endcase
        for (int a = 0; a < 3; a++)
            v[a] = 32'(clamp32(fx_mul(clamp32(m[a] + sx(m_origin[a])),
                                      64'(m_scale))));
        o = '{1'b0, v[0], v[1], v[2], f[0], f[5], vert_cnt, 1'b0};
        pending_q.push_back(o);
        br_z = line_z[col_cnt];
        if (row_cnt > 0 && col_cnt > 0) begin
            tr = vert_cnt; tl = vert_cnt - 20'd1;
            br = vert_cnt - 20'(cols); bl = vert_cnt - 20'(cols) - 20'd1;
            d1 = sx(corner_bl_z) - sx(v[2]); d2 = sx(br_z) - sx(left_z);
            if (d1 < 0) d1 = -d1;
            if (d2 < 0) d2 = -d2;
            diag = d1 > d2;
            if (wnd != WND_BACK) begin
                if (!diag) seq = '{bl, br, tl, br, tr, tl};
                else       seq = '{bl, br, tr, bl, tr, tl};
            end
            if (wnd != WND_FRONT) begin
                if (!diag) seq = {seq, bl, tl, br, br, tl, tr};
                else       seq = {seq, bl, tl, tr, br, bl, tr};
            end
            foreach (seq[k]) pending_q.push_back('{1'b1, 32'd0, 32'd0, 32'd0,
                                                  32'd0, 32'd0, seq[k], 1'b0});
            n_tris += seq.size() / 3;
        end
        corner_bl_z = br_z;
        line_z[col_cnt] = v[2];
        left_z = v[2];
        pending_q[$].lst = 1'b1;
        vert_cnt = vert_cnt + 20'd1;
        col_cnt++;
        if (col_cnt >= cols) begin
            col_cnt = 0;
            if (row_cnt < DEF_MAX_ROWS - 1) row_cnt++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_mesh_out got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32],
                    m_axis_tdata[95:64], m_axis_tdata[127:96], m_axis_tdata[159:128],
                    m_axis_tdata[179:160], m_axis_tlast};
            n_results++;
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h", $time, got);
            end else begin
                want = pending_q.pop_front();
                if (got.kind !== want.kind || got.vx !== want.vx || got.vy !== want.vy ||
                    got.vz !== want.vz || got.tu !== want.tu || got.tv !== want.tv ||
                    got.idx !== want.idx || got.lst !== want.lst) begin
                    errors++;
                    $display("%0t: mismatch expected %h actual %h", $time, want, got);
                end
            end
        end
    end

    // receiver: random stall per result, or a long hold when requested
    initial begin
        int w;
        m_axis_tready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end
            w = $urandom_range(0, 3);
            if (w != 0) begin
                m_axis_tready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready) && !rx_hold_req);
        end
    end

    task automatic cfg_write(input t_cfg_idx a, input logic [31:0] d);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= a;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (a)
            CFG_SIZE_X:   m_size[0] = d;
            CFG_SIZE_Y:   m_size[1] = d;
            CFG_SIZE_Z:   m_size[2] = d;
            CFG_ORIGIN_X: m_origin[0] = d;
            CFG_ORIGIN_Y: m_origin[1] = d;
            CFG_ORIGIN_Z: m_origin[2] = d;
            CFG_SCALE:    m_scale = d[30:0];
            default:      m_mode = d[19:0];
        endcase
    endtask

    task automatic wait_drained;
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // tvalid stays up after the transaction; the block is not ready until the point
    // is done, and the next call or wait_drained drops or reuses it
    task automatic send_point(input logic fp, input logic [31:0] f [10], input bit gap);
        int w;
        w = gap ? $urandom_range(0, 3) : 0;
        if (w != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (w) @(posedge i_clk);
        end
        predict_point(fp, f);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fp;
        s_axis_tdata  <= {f[9], f[8], f[7], f[6], f[5], f[4], f[3], f[2], f[1], f[0]};
        do @(posedge i_clk); while (!s_axis_tready);
        n_items++;
    endtask

    function automatic logic [31:0] rnd_field(input int sel);
        case (sel)
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 262144)) - 131072);
        endcase
    endfunction

    function automatic logic [19:0] mode_of(t_plane p, t_combine cx, t_combine cy,
                                            t_combine cz, t_wind wd, int cols);
        return {10'(cols), wd, cz, cy, cx, p};
    endfunction

    // Sends a grid starting at point zero; wild picks full-range fields.
    task automatic send_grid(input int npts, input bit wild);
        logic [31:0] f [10];
        for (int p = 0; p < npts; p++) begin
            foreach (f[k]) f[k] = wild ? rnd_field($urandom_range(0, 3))
                                       : rnd_field(3);
            send_point(p == 0, f, 1'b1);
        end
    endtask

    task automatic test_extremes;
        logic [31:0] f [10];
        cfg_write(CFG_MODE, mode_of(PLN_XY, CMB_SUM, CMB_SUM, CMB_SUM, WND_FRONT, 2));
        foreach (f[k]) f[k] = 32'h7fffffff;
        send_point(1'b1, f, 1'b0);
        foreach (f[k]) f[k] = 32'h80000000;
        send_point(1'b0, f, 1'b0);
        foreach (f[k]) f[k] = 32'h0;
        send_point(1'b0, f, 1'b0);
        foreach (f[k]) f[k] = 32'hffffffff;
        send_point(1'b0, f, 1'b0);
        foreach (f[k]) f[k] = 32'h55555555;
        send_point(1'b0, f, 1'b0);
        foreach (f[k]) f[k] = 32'haaaaaaaa;
        send_point(1'b0, f, 1'b0);
        wait_drained();
    endtask

    task automatic test_modes;
        // every plane, combine and winding code, including the unused ones
        for (int c = 0; c < 4; c++) begin
            cfg_write(CFG_MODE, mode_of(t_plane'(c), t_combine'(c), t_combine'((c + 1) % 4),
                                        t_combine'((c + 2) % 4), t_wind'(c), 2));
            send_grid(4, 1'b1);
            wait_drained();
        end
        // column count zero and one: no indices
        cfg_write(CFG_MODE, mode_of(PLN_XY, CMB_SUM, CMB_SUM, CMB_SUM, WND_BOTH, 0));
        send_grid(2, 1'b0);
        wait_drained();
        cfg_write(CFG_MODE, mode_of(PLN_XY, CMB_SUM, CMB_SUM, CMB_SUM, WND_BOTH, 1));
        send_grid(2, 1'b0);
        wait_drained();
    endtask

    task automatic test_registers;
        cfg_write(CFG_SIZE_X, 32'h7fffffff);
        cfg_write(CFG_SIZE_Y, 32'h80000000);
        cfg_write(CFG_SIZE_Z, 32'hffff0000);
        cfg_write(CFG_ORIGIN_X, 32'h80000000);
        cfg_write(CFG_ORIGIN_Y, 32'h7fffffff);
        cfg_write(CFG_ORIGIN_Z, 32'h00010000);
        cfg_write(CFG_SCALE, 32'h7fffffff);
        cfg_write(CFG_MODE, mode_of(PLN_XZ, CMB_MAX, CMB_MIN, CMB_SUM, WND_BOTH, 3));
        send_grid(6, 1'b1);
        wait_drained();
        cfg_write(CFG_SCALE, 32'h0);
        send_grid(4, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_grids;
        int cols, npts;
        for (int g = 0; g < 8; g++) begin
            cols = $urandom_range(2, 5);
            cfg_write(CFG_SIZE_X, (g % 3 == 0) ? $urandom : 32'h00010000 + $urandom_range(0, 65535));
            cfg_write(CFG_SIZE_Y, $urandom_range(0, 1) ? $urandom : 32'h00020000);
            cfg_write(CFG_SIZE_Z, $urandom_range(0, 1) ? $urandom : 32'hfffe8000);
            cfg_write(CFG_ORIGIN_X, $urandom);
            cfg_write(CFG_ORIGIN_Y, 32'($signed($urandom_range(0, 131072)) - 65536));
            cfg_write(CFG_ORIGIN_Z, $urandom);
            cfg_write(CFG_SCALE, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 131072));
            cfg_write(CFG_MODE, {10'(cols), 10'($urandom)});
            npts = cols * $urandom_range(2, 4);
            if (g == 3) rx_hold_req = 1'b1;
            send_grid(npts, g % 2 == 1);
            if (g == 5) wait_drained();
            wait_drained();
        end
    endtask

    task automatic test_wrap_and_shrink;
        logic [31:0] f [10];
        // column count cut mid-grid: wraps at the new count, reads only old entries
        cfg_write(CFG_MODE, mode_of(PLN_YZ, CMB_SUM, CMB_MAX, CMB_MIN, WND_BACK, 4));
        send_grid(9, 1'b0);
        wait_drained();
        cfg_write(CFG_MODE, mode_of(PLN_YZ, CMB_SUM, CMB_MAX, CMB_MIN, WND_BACK, 2));
        for (int p = 0; p < 5; p++) begin
            foreach (f[k]) f[k] = rnd_field(3);
            send_point(1'b0, f, 1'b1);
        end
        wait_drained();
        // maximal column field, few points
        cfg_write(CFG_MODE, mode_of(PLN_XY, CMB_SUM, CMB_SUM, CMB_SUM, WND_BOTH, 1023));
        send_grid(3, 1'b1);
        wait_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = CFG_SIZE_X;
        i_cfg_data = '0;
        cycle = 0;
        errors = 0; n_items = 0; n_results = 0; n_tris = 0;
        rx_hold_req = 1'b0;
        m_size = '{RST_SIZE, RST_SIZE, RST_SIZE};
        m_origin = '{32'sd0, 32'sd0, 32'sd0};
        m_scale = RST_SCALE;
        m_mode = RST_MODE;
        foreach (line_z[k]) line_z[k] = '0;
        corner_bl_z = '0; left_z = '0;
        row_cnt = 0; col_cnt = 0; vert_cnt = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_extremes();
        test_modes();
        test_registers();
        test_random_grids();
        test_wrap_and_shrink();
        wait_drained();
        $display("Covered %0d points, %0d results, %0d triangles across planes,",
                 n_items, n_results, n_tris);
        $display("combine and winding codes, saturation and column changes.");
        if (errors == 0 && pending_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
